FILE: rtl/core/shs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;

  // Start-of-message chaining value
  localparam logic [WordW-1:0] INIT_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Per-round additive constants
  localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WordW-1:0] choose(input logic [WordW-1:0] e,
                                              input logic [WordW-1:0] f,
                                              input logic [WordW-1:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [WordW-1:0] majority(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/shs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module shs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one entry, register both reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 over a byte stream. Each input item carries at most one message byte; an item
// with end_of_message set closes the message, pads it and returns the eight digest words
// (index 0 first) on the output channel, after which a new message starts. The input is
// ready only while the block is idle: a byte that does not complete a 64-byte block leaves
// the block idle. A completed block is compressed round by round, each round passing through
// S_RND1 and S_RND2 as set by the 16-word message schedule memory, whose two read ports
// supply the four schedule words each round needs. Closing a message writes the padding one
// byte per cycle up to the block end, and on into an extra block when the length does not
// fit, plus one or two compressions, then the eight words go out one per accepted cycle.
module sha256_stream_hasher
  import shs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] digest_word_o,
  output logic      [2:0]  word_index_o,
  output logic             last_word_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PAD    = 7'b0000010,
    S_CSTART = 7'b0000100,
    S_RND1   = 7'b0001000,
    S_RND2   = 7'b0010000,
    S_CADD   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e       state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  count_q, count_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic         pend_q, pend_d;
  logic         pad_done_q, pad_done_d;
  logic         len_blk_q, len_blk_d;
  logic [31:0]  chain_q [8];
  logic [31:0]  chain_d [8];
  logic [31:0]  wv_q [8];
  logic [31:0]  wv_d [8];
  logic [23:0]  acc_q, acc_d;
  logic [31:0]  sig_q, sig_d;

  logic         byte_we;
  logic [7:0]   byte_val;
  logic [7:0]   pad_byte;
  logic [63:0]  bit_len;
  logic         ram_we;
  logic [3:0]   ram_waddr;
  logic [31:0]  ram_wdata;
  logic [3:0]   ram_raddr_a;
  logic [3:0]   ram_raddr_b;
  logic [31:0]  ram_rdata_a;
  logic [31:0]  ram_rdata_b;
  logic [3:0]   rnd_next;
  logic [31:0]  w_cur;
  logic [31:0]  t1;
  logic [31:0]  t2;

  // Message schedule / block buffer memory
  shs_ram #(
    .Width(32),
    .Depth(16)
  ) u_sched_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_raddr_a),
    .raddr_b_i(ram_raddr_b),
    .rdata_a_o(ram_rdata_a),
    .rdata_b_o(ram_rdata_b)
  );

  // Select padding byte: marker, zero or big-endian bit length
  assign bit_len = {count_q, 3'b000};
  always_comb begin
    if (!pad_done_q) begin
      pad_byte = PAD_BYTE;
    end else if (len_blk_q && (fill_q[5:3] == 3'b111)) begin
      pad_byte = bit_len[{3'd7 - fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Byte write request into the block buffer
  always_comb begin
    byte_we  = 1'b0;
    byte_val = data_byte_i;
    if (state_q == S_IDLE) begin
      byte_we = in_valid_i & has_byte_i;
    end else if (state_q == S_PAD) begin
      byte_we  = 1'b1;
      byte_val = pad_byte;
    end
  end

  // Round datapath
  assign w_cur = (rnd_q[5:4] == 2'b00) ? ram_rdata_b : sig_q + ram_rdata_a + ram_rdata_b;
  assign t1 = wv_q[7] + big_sigma1(wv_q[4]) + choose(wv_q[4], wv_q[5], wv_q[6])
            + ROUND_K[rnd_q] + w_cur;
  assign t2 = big_sigma0(wv_q[0]) + majority(wv_q[0], wv_q[1], wv_q[2]);

  // Memory port control: packed words on fill, expanded words during rounds
  assign rnd_next = (state_q == S_RND2) ? rnd_q[3:0] + 4'd1 : 4'd0;
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_q[5:2];
    ram_wdata = {acc_q, byte_val};
    if (byte_we && (fill_q[1:0] == 2'b11)) begin
      ram_we = 1'b1;
    end else if ((state_q == S_RND2) && (rnd_q[5:4] != 2'b00)) begin
      ram_we    = 1'b1;
      ram_waddr = rnd_q[3:0];
      ram_wdata = w_cur;
    end
    if (state_q == S_RND1) begin
      ram_raddr_a = rnd_q[3:0] + 4'd9;
      ram_raddr_b = rnd_q[3:0];
    end else begin
      ram_raddr_a = rnd_next - 4'd2;
      ram_raddr_b = rnd_next + 4'd1;
    end
  end

  // Next-state logic
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    count_d    = count_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pad_done_d = pad_done_q;
    len_blk_d  = len_blk_q;
    chain_d    = chain_q;
    wv_d       = wv_q;
    acc_d      = acc_q;
    sig_d      = sig_q;

    if (byte_we) begin
      acc_d  = {acc_q[15:0], byte_val};
      fill_d = fill_q + 6'd1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (has_byte_i) begin
            count_d = count_q + 61'd1;
          end
          pend_d     = end_of_message_i;
          pad_done_d = 1'b0;
          len_blk_d  = 1'b0;
          if (has_byte_i && (fill_q == 6'd63)) begin
            state_d = S_CSTART;
          end else if (end_of_message_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (!pad_done_q) begin
          pad_done_d = 1'b1;
          len_blk_d  = (fill_q[5:3] != 3'b111);
        end
        if (fill_q == 6'd63) begin
          state_d = S_CSTART;
        end
      end
      S_CSTART: begin
        wv_d    = chain_q;
        rnd_d   = '0;
        state_d = S_RND1;
      end
      S_RND1: begin
        sig_d   = small_sigma1(ram_rdata_a) + small_sigma0(ram_rdata_b);
        state_d = S_RND2;
      end
      S_RND2: begin
        wv_d[7] = wv_q[6];
        wv_d[6] = wv_q[5];
        wv_d[5] = wv_q[4];
        wv_d[4] = wv_q[3] + t1;
        wv_d[3] = wv_q[2];
        wv_d[2] = wv_q[1];
        wv_d[1] = wv_q[0];
        wv_d[0] = t1 + t2;
        rnd_d   = rnd_q + 6'd1;
        state_d = (rnd_q == 6'd63) ? S_CADD : S_RND1;
      end
      S_CADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + wv_q[i];
        end
        if (pend_q && pad_done_q && len_blk_q) begin
          idx_d   = '0;
          state_d = S_OUT;
        end else if (pend_q) begin
          if (pad_done_q) begin
            len_blk_d = 1'b1;
          end
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            chain_d = INIT_CHAIN;
            count_d = '0;
            fill_d  = '0;
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and chaining registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      count_q    <= '0;
      rnd_q      <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      pad_done_q <= 1'b0;
      len_blk_q  <= 1'b0;
      chain_q    <= INIT_CHAIN;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      count_q    <= count_d;
      rnd_q      <= rnd_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
      pad_done_q <= pad_done_d;
      len_blk_q  <= len_blk_d;
      chain_q    <= chain_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    wv_q  <= wv_d;
    acc_q <= acc_d;
    sig_q <= sig_d;
  end

  // Outputs
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output active together");

  a_sched_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == S_RND2)) |->
      ((ram_waddr != ram_raddr_a) && (ram_waddr != ram_raddr_b)))
    else $error("schedule write collides with a read");

  a_full_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CADD) |-> ($past(rnd_q) == 6'd63))
    else $error("compression ended before round 63");

  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=>
      (out_valid_o && (word_index_o == $past(word_index_o) + 3'd1)))
    else $error("digest word skipped");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=>
      (in_ready_o && (fill_q == 6'd0) && (count_q == 61'd0)))
    else $error("message state not cleared after digest");

endmodule

`default_nettype wire
